@@ sv/chkv_pkg.sv @@
`default_nettype none
package chkv_pkg;

   localparam int DEFAULT_BUCKETS    = 256;
   localparam int DEFAULT_POOL_NODES = 1024;
   localparam int OPCODE_W           = 2;
   localparam int KEY_W              = 32;
   localparam int VALUE_W            = 32;
   localparam int COUNT_W            = 11;

   localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_KEY  = 2'd1,
      STATUS_POOL_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD_RD,
      ST_HEAD_LD,
      ST_FETCH,
      ST_COMPARE,
      ST_ACT,
      ST_UNLINK_CUR,
      ST_ALLOC_RD,
      ST_ALLOC_LD,
      ST_ALLOC_WR,
      ST_LINK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  value_out;
      status_type          status;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/chkv_chan_if.sv @@
`default_nettype none
interface chkv_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/chained_hash_key_value_store.sv @@
`default_nettype none
// Channel   Role   Beat
// req_chan  sink   opcode, key, value
// rsp_chan  source found, value_out, status, entry_count
//
// One request at a time. A zero key goes straight to the response; otherwise the bucket is
// found (by reciprocal modulo when BUCKETS is not a power of two), the chain is walked node
// by node up to a hit or its end with a node memory read per node, then a delete unlinks
// the node and a put on a miss allocates a new one.
// After reset the bucket head memory is swept to empty, with req_chan.ready low
// throughout. A result waits in the output register while the next is walked.
module chained_hash_key_value_store #(
   parameter int BUCKETS    = chkv_pkg::DEFAULT_BUCKETS,
   parameter int POOL_NODES = chkv_pkg::DEFAULT_POOL_NODES
) (
   input  wire logic clock,
   input  wire logic reset,
   chkv_chan_if.sink   req_chan,
   chkv_chan_if.source rsp_chan
);
   import chkv_pkg::*;

   localparam int  IW   = $clog2(POOL_NODES + 1);
   localparam int  AW   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int  BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int  NW   = IW + VALUE_W + KEY_W;
   localparam int  HS   = KEY_W + BW;
   localparam int  PW   = 2 * KEY_W + 1;
   localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam logic [IW-1:0] NIL = IW'(POOL_NODES);
   localparam logic [BW-1:0] BMASK = BW'(BUCKETS - 1);
   localparam logic [BW-1:0] BLOW  = BW'(BUCKETS);
   localparam logic [KEY_W:0] MAGIC =
      (KEY_W + 1)'(((64'd1 << HS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   state_type state_ff, state_in;

   logic [IW-1:0] heads_mem [BUCKETS];
   logic [NW-1:0] node_mem [POOL_NODES];
   logic [IW-1:0] heads_rdata_ff;
   logic [NW-1:0] node_rdata_ff;

   logic          heads_we;
   logic [BW-1:0] heads_waddr, heads_raddr;
   logic [IW-1:0] heads_wdata;
   logic          node_we;
   logic [AW-1:0] node_waddr, node_raddr;
   logic [NW-1:0] node_wdata;

   logic [OPCODE_W-1:0] op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [BW-1:0]       bucket_ff, clr_ff;
   logic [BW-1:0]       hquot_ff;
   logic                hash_ph_ff;
   logic [IW-1:0]       cur_ff, prev_ff, steps_ff, alloc_ff, next_free_ff;
   logic [IW-1:0]       free_head_ff, fresh_ff, count_ff;
   logic [NW-1:0]       curword_ff, prevword_ff;
   logic                hit_ff;
   status_type          status_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic accept, is_del, is_put, prev_valid, cur_live, match, rsp_free;
   logic [IW-1:0] cur_link, rd_link;

   assign accept     = req_chan.valid && req_chan.ready;
   assign is_del     = (op_ff == OP_DELETE) || (op_ff == OP_PUT && val_ff == '0);
   assign is_put     = (op_ff == OP_PUT) && !is_del;
   assign prev_valid = (prev_ff != NIL);
   assign cur_live   = (cur_ff != NIL) && (steps_ff != NIL);
   assign rd_link    = node_rdata_ff[NW-1 -: IW];
   assign match      = (node_rdata_ff[KEY_W-1:0] == key_ff);
   assign cur_link   = curword_ff[NW-1 -: IW];
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // memories
   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_waddr] <= heads_wdata;
      end
      heads_rdata_ff <= heads_mem[heads_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rdata_ff <= node_mem[node_raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == BMASK) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.payload.key == '0) state_in = ST_DONE;
               else if (POW2)                 state_in = ST_HEAD_RD;
               else                           state_in = ST_HASH;
            end
         end
         ST_HASH:    if (hash_ph_ff) state_in = ST_HEAD_RD;
         ST_HEAD_RD: state_in = ST_HEAD_LD;
         ST_HEAD_LD: state_in = ST_FETCH;
         ST_FETCH:   state_in = cur_live ? ST_COMPARE : ST_ACT;
         ST_COMPARE: state_in = match ? ST_ACT : ST_FETCH;
         ST_ACT: begin
            if (is_del) begin
               state_in = hit_ff ? ST_UNLINK_CUR : ST_DONE;
            end else if (is_put && !hit_ff) begin
               if (free_head_ff == NIL)           state_in = ST_DONE;
               else if (free_head_ff == fresh_ff) state_in = ST_ALLOC_WR;
               else                               state_in = ST_ALLOC_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UNLINK_CUR: state_in = ST_DONE;
         ST_ALLOC_RD:   state_in = ST_ALLOC_LD;
         ST_ALLOC_LD:   state_in = ST_ALLOC_WR;
         ST_ALLOC_WR:   state_in = ST_LINK;
         ST_LINK:       state_in = ST_DONE;
         ST_DONE:       if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      heads_we    = 1'b0;
      heads_waddr = bucket_ff;
      heads_wdata = NIL;
      heads_raddr = bucket_ff;
      node_we     = 1'b0;
      node_waddr  = cur_ff[AW-1:0];
      node_wdata  = curword_ff;
      node_raddr  = cur_ff[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            heads_we    = 1'b1;
            heads_waddr = clr_ff;
         end
         ST_ACT: begin
            if (is_del && hit_ff) begin
               // unlink from predecessor or bucket head
               if (prev_valid) begin
                  node_we    = 1'b1;
                  node_waddr = prev_ff[AW-1:0];
                  node_wdata = {cur_link, prevword_ff[VALUE_W+KEY_W-1:0]};
               end else begin
                  heads_we    = 1'b1;
                  heads_wdata = cur_link;
               end
            end else if (is_put && hit_ff) begin
               node_we    = 1'b1;
               node_wdata = {cur_link, val_ff, key_ff};
            end
         end
         ST_UNLINK_CUR: begin
            node_we    = 1'b1;
            node_wdata = {free_head_ff, curword_ff[VALUE_W+KEY_W-1:0]};
         end
         ST_ALLOC_RD: node_raddr = free_head_ff[AW-1:0];
         ST_ALLOC_WR: begin
            node_we    = 1'b1;
            node_waddr = free_head_ff[AW-1:0];
            node_wdata = {NIL, val_ff, key_ff};
         end
         ST_LINK: begin
            if (prev_valid) begin
               node_we    = 1'b1;
               node_waddr = prev_ff[AW-1:0];
               node_wdata = {alloc_ff, prevword_ff[VALUE_W+KEY_W-1:0]};
            end else begin
               heads_we    = 1'b1;
               heads_wdata = alloc_ff;
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= '0;
         fresh_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_ACT && is_put && !hit_ff && free_head_ff != NIL
             && free_head_ff == fresh_ff) begin
            fresh_ff <= fresh_ff + 1'b1;
         end
         if (state_ff == ST_ALLOC_WR) free_head_ff <= next_free_ff;
         if (state_ff == ST_UNLINK_CUR) begin
            free_head_ff <= cur_ff;
            count_ff     <= count_ff - 1'b1;
         end
         if (state_ff == ST_LINK) count_ff <= count_ff + 1'b1;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)             rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_ff      <= req_chan.payload.opcode;
               key_ff     <= req_chan.payload.key;
               val_ff     <= req_chan.payload.value;
               hit_ff     <= 1'b0;
               status_ff  <= (req_chan.payload.key == '0) ? STATUS_ZERO_KEY : STATUS_OK;
               hash_ph_ff <= 1'b0;
               bucket_ff  <= BW'(req_chan.payload.key) & BMASK;
            end
         end
         ST_HASH: begin
            // quotient by reciprocal multiply, then the remainder from the key's low bits
            if (!hash_ph_ff) begin
               hquot_ff   <= BW'((PW'(key_ff) * PW'(MAGIC)) >> HS);
               hash_ph_ff <= 1'b1;
            end else begin
               bucket_ff <= key_ff[BW-1:0] - hquot_ff * BLOW;
            end
         end
         ST_HEAD_LD: begin
            cur_ff   <= heads_rdata_ff;
            prev_ff  <= NIL;
            steps_ff <= '0;
         end
         ST_COMPARE: begin
            if (match) begin
               hit_ff     <= 1'b1;
               curword_ff <= node_rdata_ff;
            end else begin
               prev_ff     <= cur_ff;
               prevword_ff <= node_rdata_ff;
               cur_ff      <= rd_link;
               steps_ff    <= steps_ff + 1'b1;
            end
         end
         ST_ACT: begin
            if (is_put && !hit_ff) begin
               if (free_head_ff == NIL) status_ff <= STATUS_POOL_FULL;
               // untouched pool nodes link to the next index
               next_free_ff <= free_head_ff + 1'b1;
            end
         end
         ST_ALLOC_LD: next_free_ff <= rd_link;
         ST_ALLOC_WR: alloc_ff <= free_head_ff;
         ST_DONE: begin
            if (rsp_free) begin
               rsp_ff.found       <= hit_ff;
               rsp_ff.value_out   <= hit_ff ? curword_ff[VALUE_W+KEY_W-1:KEY_W] : '0;
               rsp_ff.status      <= status_ff;
               rsp_ff.entry_count <= COUNT_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

@@ sv/chkv_checker.sv @@
`default_nettype none
module chkv_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire chkv_pkg::rsp_type rsp_payload
);
   import chkv_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during head clear");

   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_ZERO_KEY
      |-> !rsp_payload.found && rsp_payload.value_out == '0)
      else $error("zero key result carries data");

   a_full_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_POOL_FULL |-> !rsp_payload.found)
      else $error("pool full reported on a hit");

endmodule

bind chained_hash_key_value_store chkv_checker u_chkv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import chkv_pkg::*;

   class kv_scoreboard;
      localparam int NBUCKETS = DEFAULT_BUCKETS;
      localparam int NPOOL    = DEFAULT_POOL_NODES;
      localparam int NIL      = DEFAULT_POOL_NODES;

      int unsigned heads[NBUCKETS];
      bit [31:0]   keys[NPOOL];
      bit [31:0]   vals[NPOOL];
      int unsigned links[NPOOL];
      int unsigned free_idx;
      int unsigned count;
      rsp_type     pending[$];
      int          errors;

      function new();
         for (int i = 0; i < NBUCKETS; i++) heads[i] = NIL;
         for (int i = 0; i < NPOOL; i++) begin
            keys[i] = '0;
            vals[i] = '0;
            links[i] = i + 1;
         end
         free_idx = 0;
         count = 0;
         errors = 0;
      endfunction

      // Apply one request to the shadow table and queue the answer it should give.
      function void note_request(req_type r);
         rsp_type     e;
         int unsigned b, prev, cur, n;
         bit          hit, del;
         bit [31:0]   old_val;
         e = '0;
         e.status = STATUS_OK;
         if (r.key == 0) begin
            e.status = STATUS_ZERO_KEY;
            e.entry_count = count[COUNT_W-1:0];
            pending.push_back(e);
            return;
         end
         b = r.key % NBUCKETS;
         prev = NIL;
         cur = heads[b];
         hit = 0;
         for (int s = 0; cur < NIL && s < NPOOL; s++) begin
            if (keys[cur] == r.key) begin
               hit = 1;
               break;
            end
            prev = cur;
            cur = links[cur];
         end
         old_val = hit ? vals[cur] : '0;
         del = (r.opcode == OP_DELETE) || (r.opcode == OP_PUT && r.value == 0);
         if (del) begin
            if (hit) begin
               if (prev < NIL) links[prev] = links[cur];
               else heads[b] = links[cur];
               links[cur] = free_idx;
               free_idx = cur;
               count--;
            end
         end else if (r.opcode == OP_PUT) begin
            if (hit) begin
               vals[cur] = r.value;
            end else if (free_idx >= NIL) begin
               e.status = STATUS_POOL_FULL;
               e.entry_count = count[COUNT_W-1:0];
               pending.push_back(e);
               return;
            end else begin
               n = free_idx;
               free_idx = links[n];
               keys[n] = r.key;
               vals[n] = r.value;
               links[n] = NIL;
               if (prev < NIL) links[prev] = n;
               else heads[b] = n;
               count++;
            end
         end
         e.found = hit;
         e.value_out = old_val;
         e.entry_count = count[COUNT_W-1:0];
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.found !== e.found) begin
            $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
            errors++;
         end
         if (a.value_out !== e.value_out) begin
            $display("%0t: value_out exp %h got %h", $time, e.value_out, a.value_out);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                     a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   chkv_chan_if #(.payload_type(req_type)) req_chan ();
   chkv_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   chained_hash_key_value_store DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   kv_scoreboard table_model;
   bit           quiet_phase;
   bit           hold_rsp;
   bit           stim_done;
   bit [31:0]    recent_keys[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         table_model.check_response(rsp_chan.payload);
      if (!reset && req_chan.valid && req_chan.ready)
         table_model.note_request(req_chan.payload);
   end

   task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] value);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= '{opcode: op, key: key, value: value};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (key != 0) recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
   endtask

   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5 && recent_keys.size() > 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      if (sel < 8) return ($urandom_range(1, 40) * DEFAULT_BUCKETS) + $urandom_range(0, 3);
      if (sel == 8) return $urandom_range(0, 3);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 9) == 0) return '0;
      return $urandom;
   endfunction

   // Receiver: random stall bursts, plus one long hold-off.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [1:0] op;
      int         wait_cycles;
      table_model = new();
      quiet_phase = 0;
      hold_rsp = 0;
      stim_done = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero key, extremes, overwrite, delete, absent delete, opcode 3.
      send_request(OP_PUT, 32'h0, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h0, 32'h0);
      send_request(OP_DELETE, 32'h0, 32'h0);
      send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_PUT, 32'h1, 32'h1);
      send_request(OP_PUT, 32'h101, 32'hA5A5_5A5A);
      send_request(OP_PUT, 32'h201, 32'h5A5A_A5A5);
      send_request(OP_GET, 32'h101, 32'h0);
      send_request(OP_PUT, 32'h101, 32'h1234_5678);
      send_request(2'd3, 32'h101, 32'hFFFF_FFFF);
      send_request(OP_DELETE, 32'h101, 32'h0);
      send_request(OP_GET, 32'h201, 32'h0);
      send_request(OP_DELETE, 32'h301, 32'h0);
      send_request(OP_PUT, 32'h301, 32'h0);
      send_request(OP_PUT, 32'h1, 32'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_DELETE, 32'h8000_0000, 32'h0);

      // Long hold-off while requests keep coming.
      hold_rsp = 1;
      for (int i = 0; i < 20; i++) send_request(OP_PUT, pick_key(), pick_value());

      for (int i = 0; i < 400; i++) begin
         op = $urandom_range(0, 9) < 5 ? OP_PUT : 2'($urandom_range(1, 3));
         send_request(op, pick_key(), pick_value());
      end

      // Burst of puts with mostly fresh keys.
      for (int i = 0; i < 250; i++)
         send_request(OP_PUT, 32'($urandom_range(1, 32'h7FFF_FFFF)) | 32'h1, $urandom | 1);
      for (int i = 0; i < 30; i++)
         send_request(2'($urandom_range(0, 3)), pick_key(), pick_value());

      quiet_phase = 1;
      for (int i = 0; i < 30; i++)
         send_request(2'($urandom_range(0, 3)), pick_key(), pick_value());
      req_chan.valid <= 1'b0;

      wait_cycles = 0;
      while (table_model.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #200ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/chkv_pkg.sv
sv/chkv_chan_if.sv
sv/chained_hash_key_value_store.sv
sv/chkv_checker.sv
sim/testbench.sv
